// ===== hw/rtl/fua_pkg.sv =====
// ----------------------------------------------------------------------------
// fua_pkg
// Shared types and constants for the H.264 RTP FU-A packetizer: request and
// result payloads, the command passed from front to back, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fua_pkg;

    localparam logic [16:0] MAX_FRAME_BYTES = 17'd65536;
    localparam logic [10:0] PAYLOAD_MIN     = 11'd1024;
    localparam logic [10:0] PAYLOAD_MAX     = 11'd1400;
    localparam logic [7:0]  FU_INDICATOR    = 8'h7C;
    localparam logic [7:0]  FU_START        = 8'h80;
    localparam logic [7:0]  FU_END          = 8'h40;
    localparam logic [31:0] START_CODE4     = 32'h0000_0001;
    localparam logic [5:0]  MAX_FRAGS_M1    = 6'd63;

    // Configuration register indexes and reset values.
    localparam int          CFG_IDX_W        = 2;
    localparam int          CFG_DATA_W       = 17;
    localparam logic [1:0]  CFG_MAX_PAYLOAD  = 2'd0;
    localparam logic [1:0]  CFG_PAYLOAD_TYPE = 2'd1;
    localparam logic [1:0]  CFG_TS_STEP      = 2'd2;
    localparam logic [10:0] RST_MAX_PAYLOAD  = 11'd1300;
    localparam logic [6:0]  RST_PAYLOAD_TYPE = 7'd96;
    localparam logic [16:0] RST_TS_STEP      = 17'd3750;

    // Command queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic [31:0] lead_bytes;
        logic [7:0]  fifth_byte;
        logic [16:0] frame_length;
    } t_in;

    typedef struct packed {
        logic [31:0] header_word;
        logic [31:0] media_timestamp;
        logic        is_fragment;
        logic [7:0]  fu_indicator;
        logic [7:0]  fu_header;
        logic [15:0] payload_offset;
        logic [10:0] payload_length;
        logic        last_packet;
    } t_out;

    typedef struct packed {
        logic        single;
        logic [4:0]  nal_type;
        logic [15:0] offset;
        logic [16:0] rest;
        logic [10:0] first_cap;
        logic [10:0] mtu;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/fua_front.sv =====
// ----------------------------------------------------------------------------
// fua_front
// Classifies one frame request: start code length, NAL header, clamped
// payload limit, single packet or FU-A split, and builds the back command.
// ----------------------------------------------------------------------------
`default_nettype none

module fua_front (
    input  var fua_pkg::t_in  i_req,
    input  wire logic [10:0]  i_max_payload,
    output fua_pkg::t_cmd     o_cmd,
    output logic              o_empty
);

    logic [10:0] mtu;
    logic [16:0] flen;
    logic        four;
    logic [2:0]  sep;
    logic [7:0]  nal_hdr;
    logic [16:0] nal_len;
    logic        single;
    logic [16:0] rest;

    always_comb begin
        if (i_max_payload < fua_pkg::PAYLOAD_MIN) begin
            mtu = fua_pkg::PAYLOAD_MIN;
        end else if (i_max_payload > fua_pkg::PAYLOAD_MAX) begin
            mtu = fua_pkg::PAYLOAD_MAX;
        end else begin
            mtu = i_max_payload;
        end

        flen = (i_req.frame_length > fua_pkg::MAX_FRAME_BYTES) ?
               fua_pkg::MAX_FRAME_BYTES : i_req.frame_length;

        four    = (i_req.lead_bytes == fua_pkg::START_CODE4);
        sep     = four ? 3'd4 : 3'd3;
        nal_hdr = four ? i_req.fifth_byte : i_req.lead_bytes[7:0];

        o_empty = (flen <= {14'd0, sep});
        nal_len = flen - {14'd0, sep};
        single  = (nal_len <= {6'd0, mtu});
        rest    = single ? nal_len : nal_len - 17'd1;

        o_cmd.single   = single;
        o_cmd.nal_type = nal_hdr[4:0];
        o_cmd.offset   = single ? {13'd0, sep} : {13'd0, sep} + 16'd1;
        o_cmd.rest     = rest;
        o_cmd.mtu      = mtu;
        // A remainder that fits one fragment exactly is split in two so the
        // start and end bits never land in the same FU header.
        o_cmd.first_cap = (!single && rest == {6'd0, mtu}) ? mtu - 11'd1 : mtu;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fua_queue.sv =====
// ----------------------------------------------------------------------------
// fua_queue
// Two-entry command queue that decouples request classification from
// packet generation.
// ----------------------------------------------------------------------------
`default_nettype none

module fua_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  var fua_pkg::t_cmd   i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output fua_pkg::t_cmd       o_cmd
);

    fua_pkg::t_cmd                r_mem [fua_pkg::Q_DEPTH];
    logic [fua_pkg::Q_AW-1:0]     r_wr;
    logic [fua_pkg::Q_AW-1:0]     r_rd;
    logic [fua_pkg::Q_AW:0]       r_cnt;

    assign o_full  = (r_cnt == (fua_pkg::Q_AW+1)'(fua_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fua_back.sv =====
// ----------------------------------------------------------------------------
// fua_back
// Walks one command and emits its descriptors, one per cycle unless stalled,
// into an output register. Holds the RTP sequence number and media timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

module fua_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  var fua_pkg::t_cmd   i_cmd,
    output logic                o_cmd_pop,
    input  wire logic [6:0]     i_payload_type,
    input  wire logic [16:0]    i_ts_step,
    output logic                o_valid,
    input  wire logic           i_ready,
    output fua_pkg::t_out       o_data
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state        r_state;
    logic          r_single;
    logic          r_first;
    logic [5:0]    r_cnt;
    logic [4:0]    r_type;
    logic [15:0]   r_off;
    logic [16:0]   r_rest;
    logic [10:0]   r_first_cap;
    logic [10:0]   r_mtu;
    logic [15:0]   r_seq;
    logic [31:0]   r_ts;
    logic          r_out_valid;
    fua_pkg::t_out r_out;

    logic          emit;
    logic [10:0]   cap;
    logic          fits;
    logic [16:0]   len;
    logic          done;
    fua_pkg::t_out n_out;

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign emit      = (r_state == ST_RUN) && (!r_out_valid || i_ready);
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    always_comb begin
        cap  = r_first ? r_first_cap : r_mtu;
        fits = (r_rest <= {6'd0, cap});
        len  = fits ? r_rest : {6'd0, cap};
        // Fragment count limit: a frame ends after its 64th packet.
        done = fits || (r_cnt == fua_pkg::MAX_FRAGS_M1);

        n_out.header_word     = {2'b10, 1'b0, 1'b0, 4'd0, 1'b0, i_payload_type, r_seq};
        n_out.media_timestamp = r_ts;
        n_out.is_fragment     = !r_single;
        n_out.fu_indicator    = r_single ? 8'd0 : fua_pkg::FU_INDICATOR;
        if (r_single) begin
            n_out.fu_header = 8'd0;
        end else begin
            n_out.fu_header = {3'd0, r_type}
                            | (r_first ? fua_pkg::FU_START : 8'd0)
                            | (fits ? fua_pkg::FU_END : 8'd0);
        end
        n_out.payload_offset = r_off;
        n_out.payload_length = len[10:0];
        n_out.last_packet    = fits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seq       <= '0;
            r_ts        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state     <= ST_RUN;
                        r_single    <= i_cmd.single;
                        r_first     <= 1'b1;
                        r_cnt       <= '0;
                        r_type      <= i_cmd.nal_type;
                        r_off       <= i_cmd.offset;
                        r_rest      <= i_cmd.rest;
                        r_first_cap <= i_cmd.first_cap;
                        r_mtu       <= i_cmd.mtu;
                    end
                end
                ST_RUN: begin
                    if (emit) begin
                        r_seq   <= r_seq + 16'd1;
                        r_first <= 1'b0;
                        r_cnt   <= r_cnt + 6'd1;
                        r_off   <= r_off + {5'd0, len[10:0]};
                        r_rest  <= r_rest - len;
                        if (done) begin
                            r_ts    <= r_ts + {15'd0, i_ts_step};
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/h264_rtp_fua_packetizer_core.sv =====
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_core
// Turns H.264 frame requests into RTP packet descriptors with FU-A splitting.
// ----------------------------------------------------------------------------
// Usage:
// A request carries the first five frame bytes and the frame length on the
// input valid/ready channel. Each packet descriptor leaves on the output
// valid/ready channel: RTP header word, timestamp, FU-A prefix bytes and the
// span of frame bytes that the packet copies.
// The front classifies a request in the cycle it is accepted and places a
// command in a two-entry queue; requests with no NAL bytes are accepted and
// dropped. The back loads a queued command into its registers while idle and
// then emits one packet per cycle into the output register while that is not
// stalled; it takes no new command until a frame's last packet (at most the
// 64th) is emitted. The back's packet loop sets the sustained rate. Input
// ready is low only while the queue is full. When the receiver stalls, the
// output register holds its packet and the back waits; the queue keeps
// taking requests until it fills. Reset clears the queue, sequence number
// and timestamp and sets the registers to payload limit 1300, payload type
// 96 and timestamp step 3750. The user must write registers through the
// plain write port only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_rtp_fua_packetizer_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [fua_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fua_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  var fua_pkg::t_in                      i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output fua_pkg::t_out                         o_out_data
);

    logic [10:0]   r_max_payload;
    logic [6:0]    r_payload_type;
    logic [16:0]   r_ts_step;

    fua_pkg::t_cmd front_cmd;
    fua_pkg::t_cmd q_cmd;
    logic          front_empty;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          q_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload  <= fua_pkg::RST_MAX_PAYLOAD;
            r_payload_type <= fua_pkg::RST_PAYLOAD_TYPE;
            r_ts_step      <= fua_pkg::RST_TS_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fua_pkg::CFG_MAX_PAYLOAD:  r_max_payload  <= i_cfg_wdata[10:0];
                fua_pkg::CFG_PAYLOAD_TYPE: r_payload_type <= i_cfg_wdata[6:0];
                fua_pkg::CFG_TS_STEP:      r_ts_step      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !q_full;
    assign q_push     = i_in_valid && !q_full && !front_empty;

    fua_front u_front (
        .i_req         (i_in_data),
        .i_max_payload (r_max_payload),
        .o_cmd         (front_cmd),
        .o_empty       (front_empty)
    );

    fua_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    fua_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_cmd_pop      (q_pop),
        .i_payload_type (r_payload_type),
        .i_ts_step      (r_ts_step),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_data         (o_out_data)
    );

endmodule

`default_nettype wire
